// ===== hw/rtl/tfc_pkg.sv =====
`default_nettype none

package tfc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int IDX_W     = 6;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int OUT_W     = 16;
    localparam int FRAC_BITS = 15;

    // Coefficient slots reachable through the index field
    localparam int COEF_SLOTS = 1 << IDX_W;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [OUT_W-1:0] SAT_MIN = 16'sh8000;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_LOAD   = 1'b1
    } tfc_mode_t;

    typedef struct packed {
        logic coef_we;
        logic mult_en;
        logic shift_en;
    } tfc_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tfc_cell.sv =====
`default_nettype none

module tfc_cell
    import tfc_pkg::*;
#(
    parameter int ACC_W = 38
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tfc_cell_ctrl_t           ctrl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [COEF_W-1:0] coef_value,
    input  wire logic signed [ACC_W-1:0]  tap_in,
    output logic signed [ACC_W-1:0]       tap_out
);

    logic signed [COEF_W-1:0] coef_reg;
    logic signed [COEF_W-1:0] coef_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  psum_reg;
    logic signed [ACC_W-1:0]  psum_next;

    always_comb
    begin
        coef_next = ctrl.coef_we ? coef_value : coef_reg;
        prod_next = ctrl.mult_en ? PROD_W'(sample) * PROD_W'(coef_reg) : prod_reg;
        psum_next = ctrl.shift_en ? tap_in : psum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            psum_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
            psum_reg <= psum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Partial sum plus this tap's term, handed to the left neighbour
    assign tap_out = psum_reg + ACC_W'(prod_reg);

endmodule

`default_nettype wire

// ===== hw/rtl/tfc_out.sv =====
`default_nettype none

module tfc_out
    import tfc_pkg::*;
#(
    parameter int ACC_W = 38
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    sum_valid,
    input  wire logic signed [ACC_W-1:0] sum,
    output logic                         sum_pending,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OUT_DATA_W-1:0]        m_tdata,   // filtered[15:0]
    output logic                         m_tuser    // clipped
);

    logic                    acc_valid_reg;
    logic                    acc_valid_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [OUT_W-1:0] out_data_reg;
    logic signed [OUT_W-1:0] out_data_next;
    logic                    out_clip_reg;
    logic                    out_clip_next;

    logic                    move;
    logic signed [ACC_W:0]   rounded;
    logic                    sign;
    logic                    pos_ovf;
    logic                    neg_ovf;

    assign move = acc_valid_reg && (!out_valid_reg || m_tready);

    // Round half up, then the sign and upper bits decide saturation
    always_comb
    begin
        rounded = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
        sign    = rounded[ACC_W];
        pos_ovf = !sign && (|rounded[ACC_W-1:FRAC_BITS+OUT_W-1]);
        neg_ovf = sign && !(&rounded[ACC_W-1:FRAC_BITS+OUT_W-1]);
    end

    always_comb
    begin
        acc_valid_next = acc_valid_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_clip_next  = out_clip_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (move)
        begin
            acc_valid_next = 1'b0;
            out_valid_next = 1'b1;
            out_clip_next  = pos_ovf || neg_ovf;
            if (pos_ovf)
            begin
                out_data_next = SAT_MAX;
            end
            else if (neg_ovf)
            begin
                out_data_next = SAT_MIN;
            end
            else
            begin
                out_data_next = rounded[FRAC_BITS+OUT_W-1:FRAC_BITS];
            end
        end

        if (sum_valid)
        begin
            acc_valid_next = 1'b1;
            acc_next       = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_valid_reg <= acc_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        out_clip_reg <= out_clip_next;
    end

    assign sum_pending = acc_valid_reg;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;
    assign m_tuser     = out_clip_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/transposed_fir_convolver.sv =====
// A sample transfer goes to m_tdata through the product registers, the accumulator
//   register and the output register, which holds its result while m_tready is low.
// No new sample is taken until the multiply step, the add/shift step of the cell chain
//   and, once warm, the accumulator stage are through; a full output also holds the input.
// Reset (rst_n low, asynchronous) clears all coefficients, partial sums and the
//   warm-up count; the first TAPS-1 samples after reset give no result.
`default_nettype none

module transposed_fir_convolver
    import tfc_pkg::*;
#(
    parameter int TAPS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // sample[15:0], coef_index[21:16],
                                                  // coef_value[37:22], zero pad
    input  wire logic                  s_tuser,   // mode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // filtered[15:0]
    output logic                       m_tuser    // clipped
);

    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int FILL_W = $clog2(TAPS + 1);

    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    tfc_mode_t                  mode;

    logic                       in_xfer;
    logic                       sample_xfer;
    logic                       load_xfer;

    logic                       busy_reg;
    logic                       busy_next;
    logic [FILL_W-1:0]          fill_reg;
    logic [FILL_W-1:0]          fill_next;
    logic                       emit;
    logic                       sum_pending;

    logic signed [ACC_W-1:0]    tap_chain [TAPS];

    assign sample     = s_tdata[SAMPLE_W-1:0];
    assign coef_index = s_tdata[SAMPLE_W+IDX_W-1:SAMPLE_W];
    assign coef_value = s_tdata[SAMPLE_W+IDX_W+COEF_W-1:SAMPLE_W+IDX_W];
    assign mode       = tfc_mode_t'(s_tuser);

    assign s_tready    = !busy_reg && !sum_pending;
    assign in_xfer     = s_tvalid && s_tready;
    assign sample_xfer = in_xfer && (mode == MODE_SAMPLE);
    assign load_xfer   = in_xfer && (mode == MODE_LOAD);

    // Shift the chain the cycle after the products are registered; advance the fill count
    always_comb
    begin
        busy_next = sample_xfer;
        fill_next = fill_reg;
        if (busy_reg && (fill_reg != FILL_W'(TAPS)))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    assign emit = busy_reg && (fill_reg >= FILL_W'(TAPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fill_reg <= fill_next;
        end
    end

    for (genvar j = 0; j < TAPS; j++)
    begin : g_cell
        tfc_cell_ctrl_t          ctrl;
        logic signed [ACC_W-1:0] tap_in;

        if (j < COEF_SLOTS)
        begin : g_we
            assign ctrl.coef_we = load_xfer && (coef_index == IDX_W'(j));
        end
        else
        begin : g_no_we
            assign ctrl.coef_we = 1'b0;
        end

        assign ctrl.mult_en  = sample_xfer;
        assign ctrl.shift_en = busy_reg;

        if (j == TAPS - 1)
        begin : g_tail
            assign tap_in = '0;
        end
        else
        begin : g_link
            assign tap_in = tap_chain[j+1];
        end

        tfc_cell #(
            .ACC_W (ACC_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sample     (sample),
            .coef_value (coef_value),
            .tap_in     (tap_in),
            .tap_out    (tap_chain[j])
        );
    end

    tfc_out #(
        .ACC_W (ACC_W)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .sum_valid   (emit),
        .sum         (tap_chain[0]),
        .sum_pending (sum_pending),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tfc_checker.sv =====
`default_nettype none

module tfc_checker
    import tfc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tuser
);

    // The chain cannot take anything while a sample is being summed
    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == MODE_SAMPLE)) |=> !s_tready)
        else $error("input accepted while a sample was in the chain");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // A clipped result sits on one of the two rails
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> ((m_tdata == SAT_MAX) || (m_tdata == SAT_MIN)))
        else $error("clipped result not at a saturation value");

    // A fresh result must trace back to an accepted sample transfer
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == MODE_SAMPLE), 3))
        else $error("result without a matching sample");

endmodule

bind transposed_fir_convolver tfc_checker u_tfc_checker (.*);

`default_nettype wire

// ===== tb/sv/convolver_checker.sv =====
`default_nettype none

module convolver_checker
    import tfc_pkg::*;
#(
    parameter int TAPS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // sample[15:0], coef_index[21:16],
                                                  // coef_value[37:22], zero pad
    input  wire logic                  s_tuser,   // mode
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,   // filtered[15:0]
    input  wire logic                  m_tuser,   // clipped
    output int                         errors,
    output int                         pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_LSB  = SAMPLE_W;
    localparam int COEF_LSB = SAMPLE_W + IDX_W;

    typedef struct {
        logic signed [OUT_W-1:0] filtered;
        logic                    clipped;
    } filter_result_t;

    longint                   ring_sums [TAPS];
    logic signed [COEF_W-1:0] tap_weights [TAPS];
    int                       ring_head;
    int                       fill_count;
    int                       mismatches;
    filter_result_t           pending_filtered [$];

    // Load a tap weight, or scatter a sample over the ring and retire the head slot
    task automatic convolve_item(input logic [IN_DATA_W-1:0] data, input logic mode);
        logic signed [SAMPLE_W-1:0] x;
        longint                     acc;
        longint                     y;
        filter_result_t             res;
        if (tfc_mode_t'(mode) == MODE_LOAD) begin
            if (int'(data[IDX_LSB +: IDX_W]) < TAPS)
                tap_weights[data[IDX_LSB +: IDX_W]] = data[COEF_LSB +: COEF_W];
            return;
        end
        x = data[SAMPLE_W-1:0];
        for (int k = 0; k < TAPS; k++)
            ring_sums[(ring_head + k) % TAPS] += longint'(x) * longint'(tap_weights[k]);
        if (fill_count < TAPS)
            fill_count++;
        acc = ring_sums[ring_head];
        ring_sums[ring_head] = 0;
        ring_head = (ring_head + 1) % TAPS;
        if (fill_count < TAPS)
            return;
        // round half up, then floor shift
        y = (acc + 64'sd16384) >>> FRAC_BITS;
        res.clipped = 1'b0;
        if (y > longint'(SAT_MAX)) begin
            y = longint'(SAT_MAX);
            res.clipped = 1'b1;
        end
        else if (y < longint'(SAT_MIN)) begin
            y = longint'(SAT_MIN);
            res.clipped = 1'b1;
        end
        res.filtered = y[OUT_W-1:0];
        pending_filtered.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        filter_result_t want;
        if (!rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                ring_sums[k]   = 0;
                tap_weights[k] = '0;
            end
            ring_head  = 0;
            fill_count = 0;
            mismatches = 0;
            pending_filtered.delete();
        end
        else begin
            // retire before predicting: a result never leaves in its own input's cycle
            if (m_tvalid && m_tready) begin
                if (pending_filtered.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no result, got filtered %0d clipped %0b",
                             $time, $signed(m_tdata), m_tuser);
                end
                else begin
                    want = pending_filtered.pop_front();
                    if (m_tdata !== want.filtered) begin
                        mismatches++;
                        $display("%0t: filtered expected %0d got %0d",
                                 $time, want.filtered, $signed(m_tdata));
                    end
                    if (m_tuser !== want.clipped) begin
                        mismatches++;
                        $display("%0t: clipped expected %0b got %0b",
                                 $time, want.clipped, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
                convolve_item(s_tdata, s_tuser);
        end
        errors  <= mismatches;
        pending <= pending_filtered.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/transposed_fir_convolver_tb.sv =====
`default_nettype none

module transposed_fir_convolver_tb;
    import tfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS        = 64;
    localparam int ITEMS       = 1300;
    localparam int STALL_LIMIT = 5000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;  // sample[15:0], coef_index[21:16],
                                           // coef_value[37:22], zero pad
    logic                  s_tuser  = MODE_SAMPLE;  // mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // filtered[15:0]
    logic                  m_tuser;        // clipped

    logic steady = 1'b0;
    int   sent   = 0;
    int   errors;
    int   pending;
    int   quiet_cycles = 0;

    always #5 clk = ~clk;

    transposed_fir_convolver #(
        .TAPS(TAPS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    convolver_checker #(
        .TAPS(TAPS)
    ) checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .errors  (errors),
        .pending (pending)
    );

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= 36);

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // 0: full range, 1: small around zero, otherwise a rail, zero, one or minus one
    function automatic logic [15:0] pick_value(input int span);
        case (span)
            0: return 16'($urandom);
            1: return 16'($urandom_range(511)) - 16'd256;
            default: begin
                case ($urandom_range(4))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'hffff;
                    default: return 16'h0001;
                endcase
            end
        endcase
    endfunction

    // Present one transfer; hold it until the block takes it
    task automatic push_item(input logic mode, input logic [15:0] smp,
                             input logic [IDX_W-1:0] idx, input logic [15:0] cval);
        while (!steady && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= IN_DATA_W'({cval, idx, smp});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic load_tap(input logic [IDX_W-1:0] idx, input logic [15:0] cval);
        push_item(MODE_LOAD, 16'($urandom), idx, cval);
    endtask

    task automatic feed_sample(input logic [15:0] smp);
        push_item(MODE_SAMPLE, smp, IDX_W'($urandom), 16'($urandom));
    endtask

    initial
    begin : stimulus
        int coef_span;
        int smp_span;
        int burst;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // half weight on tap 0 exercises rounding; extremes on alternating index bits
        load_tap(6'd0, 16'h4000);
        load_tap(6'd63, 16'h8000);
        load_tap(6'd42, 16'h7fff);
        load_tap(6'd21, 16'hffff);
        feed_sample(16'h0001);
        feed_sample(16'hffff);
        feed_sample(16'h7fff);
        feed_sample(16'h8000);
        feed_sample(16'h0000);
        feed_sample(16'h5555);
        feed_sample(16'haaaa);
        // reload mid-stream: sums in flight mix old and new weights
        load_tap(6'd0, 16'h7fff);
        load_tap(6'd1, 16'h7fff);
        load_tap(6'd2, 16'h8000);
        repeat (3) feed_sample(16'h7fff);
        repeat (3) feed_sample(16'h8000);
        feed_sample(16'h0001);

        while (sent < ITEMS) begin
            steady    <= (sent >= 500 && sent < 800);
            coef_span = $urandom_range(2);
            smp_span  = $urandom_range(2);
            case ($urandom_range(3))
                0: begin
                    // mostly zero weights keep many outputs inside range
                    for (int k = 0; k < TAPS; k++)
                        load_tap(IDX_W'(k),
                                 ($urandom_range(7) == 0) ? pick_value(coef_span) : 16'h0000);
                end
                1: begin
                    repeat ($urandom_range(1, 16))
                        load_tap(IDX_W'($urandom), pick_value(coef_span));
                end
                default: ;
            endcase
            burst = $urandom_range(20, 120);
            repeat (burst) begin
                if ($urandom_range(9) == 0)
                    load_tap(IDX_W'($urandom), pick_value($urandom_range(2)));
                else
                    feed_sample(pick_value(smp_span));
            end
        end
        steady   <= 1'b0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
